@@ design/mbps_pkg.sv @@
// Shared widths, request codes and queue entry type of the masked byte pattern scanner.
package mbps_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int CFG_W           = 7;
	localparam int REQ_W           = 2;
	localparam int SLOT_W          = 6;
	localparam int BYTE_W          = 8;
	localparam int ADDR_W          = 32;

	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DATA  = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_START,
		OP_DATA
	} mbps_op_t;

	typedef struct packed {
		mbps_op_t            op;
		logic [SLOT_W-1:0]   slot_index;
		logic [BYTE_W-1:0]   pattern_byte;
		logic                care;
		logic [ADDR_W-1:0]   start_address;
		logic [BYTE_W-1:0]   data_byte;
		logic                last;
	} mbps_entry_t;

endpackage

@@ design/mbps_if.sv @@
// Channel interfaces of the masked byte pattern scanner: request, result and configuration.
interface mbps_req_if import mbps_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [SLOT_W-1:0]  slot_index;
	logic [BYTE_W-1:0]  pattern_byte;
	logic               care;
	logic [ADDR_W-1:0]  start_address;
	logic [BYTE_W-1:0]  data_byte;
	logic               last;

	modport source(output valid, req_type, slot_index, pattern_byte, care, start_address,
		data_byte, last, input ready);
	modport sink(input valid, req_type, slot_index, pattern_byte, care, start_address,
		data_byte, last, output ready);
endinterface

interface mbps_res_if import mbps_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               found;
	logic [ADDR_W-1:0]  match_address;

	modport source(output valid, found, match_address, input ready);
	modport sink(input valid, found, match_address, output ready);
endinterface

interface mbps_cfg_if import mbps_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CFG_W-1:0]   pattern_length;

	modport source(output valid, pattern_length, input ready);
	modport sink(input valid, pattern_length, output ready);
endinterface

@@ design/masked_byte_pattern_scanner.sv @@
// Top level of the masked byte pattern scanner.
// The scanner finds the first place in a streamed byte range where a pattern with
// wildcard positions occurs. Write items load one pattern byte and its care bit into a
// slot, a start item gives the address of the first byte and arms the scan, and data
// items then stream the range one byte per item, with last set on the final byte. The
// block returns one result item per scan: found with the address of the first matched
// byte, or not found with address zero when the last byte completes no match. Data items
// outside a scan and items with an unknown request code are taken and produce nothing.
// Throughput is one item per clock while results are taken and no pattern copy runs: the
// front end accepts into a two-entry queue and the scan engine executes one item per cycle,
// comparing the whole window against the pattern in parallel. A result is registered: a
// data item passes through the queue and then the result register before its result is
// offered. The engine holds while that result is not taken, and the queue keeps accepting
// until it fills. A write of pattern_length makes the engine copy the pattern from its RAM
// into the aligned compare register, one slot per cycle; items queue up but are not
// executed during that copy. No clearing pass follows reset. The configuration port
// is always ready.
module masked_byte_pattern_scanner import mbps_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mbps_req_if.sink    req,
	mbps_res_if.source  res,
	mbps_cfg_if.sink    cfg
);

	logic         push;
	logic         full;
	logic         pop;
	logic         head_valid;
	mbps_entry_t  push_entry;
	mbps_entry_t  head;

	// The front end decodes request codes and fills the queue.
	mbps_front u_front (
		.req        (req),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue lets the front end keep taking items while the engine waits on the result side.
	mbps_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The engine owns the pattern, the byte window, the scan state and the result register.
	mbps_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg),
		.res        (res)
	);

endmodule

@@ design/mbps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/mbps_front.sv @@
// Front end: accepts request items, classifies them and pushes known ones into the queue.
module mbps_front import mbps_pkg::*; (
	mbps_req_if.sink      req,
	input  logic          full,
	output logic          push,
	output mbps_entry_t   push_entry
);

	logic known;

	assign req.ready = !full;

	always_comb begin
		push_entry.slot_index    = req.slot_index;
		push_entry.pattern_byte  = req.pattern_byte;
		push_entry.care          = req.care;
		push_entry.start_address = req.start_address;
		push_entry.data_byte     = req.data_byte;
		push_entry.last          = req.last;
		known                    = 1'b1;
		unique case (req.req_type)
			REQ_WRITE: push_entry.op = OP_WRITE;
			REQ_START: push_entry.op = OP_START;
			REQ_DATA:  push_entry.op = OP_DATA;
			default: begin
				// Unknown request codes are taken and dropped here.
				push_entry.op = OP_DATA;
				known         = 1'b0;
			end
		endcase
	end

	assign push = req.valid && req.ready && known;

endmodule

@@ design/mbps_fifo.sv @@
// Short queue between the front end and the scan engine.
module mbps_fifo import mbps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbps_entry_t   push_entry,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output mbps_entry_t   head
);

	mbps_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ design/mbps_back.sv @@
// Scan engine: pattern store, aligned compare register, byte window and result register.
module mbps_back import mbps_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  mbps_entry_t   head,
	output logic          pop,
	mbps_cfg_if.sink      cfg,
	mbps_res_if.source    res
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int EW = (LW > CFG_W) ? LW : CFG_W;
	localparam int CW = (LW > SLOT_W) ? LW : SLOT_W;
	localparam int PW = BYTE_W + 1;

	logic [LW-1:0]      len_q;
	logic [LW-1:0]      len_new;
	logic [EW-1:0]      raw_len;
	logic               cfg_we;

	logic               sweep_busy_q;
	logic [LW-1:0]      sweep_w_q;
	logic               issue;
	logic [LW-1:0]      sweep_diff;
	logic               rd_valid_s1;
	logic [AW-1:0]      rd_pos_s1;
	logic [PW-1:0]      ram_rdata;

	logic [PW-1:0]      pat_al_q [MAX_PATTERN];
	logic [BYTE_W-1:0]  win_q [MAX_PATTERN];
	logic [BYTE_W-1:0]  win_new [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] pos_ok;

	logic               scanning_q;
	logic [LW-1:0]      seen_q;
	logic [LW-1:0]      seen_new;
	logic [ADDR_W-1:0]  cur_addr_q;
	logic [ADDR_W-1:0]  match_addr;

	logic               go;
	logic               is_data;
	logic               hit;
	logic               produce;
	logic               ram_we;
	logic               al_we;
	logic [CW-1:0]      al_diff;

	logic               out_valid_q;
	logic               found_q;
	logic [ADDR_W-1:0]  addr_q;

	// Configuration
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign raw_len   = EW'(cfg.pattern_length);

	always_comb begin
		priority if (raw_len == '0) begin
			len_new = LW'(1);
		end else if (raw_len > EW'(MAX_PATTERN)) begin
			len_new = LW'(MAX_PATTERN);
		end else begin
			len_new = raw_len[LW-1:0];
		end
	end

	// Item execution
	assign go      = head_valid && !sweep_busy_q && (!out_valid_q || res.ready);
	assign pop     = go;
	assign is_data = go && (head.op == OP_DATA) && scanning_q;

	assign seen_new = (seen_q == LW'(MAX_PATTERN)) ? seen_q : seen_q + LW'(1);

	always_comb begin
		win_new[0] = head.data_byte;
		for (int w = 1; w < MAX_PATTERN; w++) begin
			win_new[w] = win_q[w-1];
		end
		for (int w = 0; w < MAX_PATTERN; w++) begin
			pos_ok[w] = (LW'(w) >= len_q) || !pat_al_q[w][BYTE_W]
				|| (win_new[w] == pat_al_q[w][BYTE_W-1:0]);
		end
	end

	assign hit        = (seen_new >= len_q) && (&pos_ok);
	assign produce    = is_data && (hit || head.last);
	assign match_addr = cur_addr_q - ADDR_W'(len_q) + ADDR_W'(1);

	// Pattern writes go to the raw store and, when inside the length, to the aligned copy.
	assign ram_we  = go && (head.op == OP_WRITE) && (CW'(head.slot_index) < CW'(MAX_PATTERN));
	assign al_we   = go && (head.op == OP_WRITE) && (CW'(head.slot_index) < CW'(len_q));
	assign al_diff = CW'(len_q) - CW'(1) - CW'(head.slot_index);

	// Realignment sweep after a length change.
	assign issue      = sweep_busy_q && (sweep_w_q < len_q);
	assign sweep_diff = len_q - LW'(1) - sweep_w_q;

	mbps_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_PATTERN)
	) u_pattern_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(head.slot_index)),
		.wdata ({head.care, head.pattern_byte}),
		.re    (issue),
		.raddr (sweep_diff[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			pat_al_q[rd_pos_s1] <= ram_rdata;
		end else if (al_we) begin
			pat_al_q[al_diff[AW-1:0]] <= {head.care, head.pattern_byte};
		end
	end

	always_ff @(posedge clk) begin
		if (is_data) begin
			win_q <= win_new;
		end
		if (issue) begin
			rd_pos_s1 <= sweep_w_q[AW-1:0];
		end
		if (produce) begin
			found_q <= hit;
			addr_q  <= hit ? match_addr : '0;
		end
		if (go && (head.op == OP_START)) begin
			cur_addr_q <= head.start_address;
		end else if (is_data) begin
			cur_addr_q <= cur_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LW'(1);
			sweep_busy_q <= 1'b0;
			sweep_w_q    <= '0;
			rd_valid_s1  <= 1'b0;
			scanning_q   <= 1'b0;
			seen_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cfg_we) begin
				len_q        <= len_new;
				sweep_busy_q <= 1'b1;
				sweep_w_q    <= '0;
			end else if (sweep_busy_q) begin
				if (issue) begin
					sweep_w_q <= sweep_w_q + LW'(1);
				end else if (!rd_valid_s1) begin
					sweep_busy_q <= 1'b0;
				end
			end

			if (go) begin
				unique case (head.op)
					OP_START: begin
						scanning_q <= 1'b1;
						seen_q     <= '0;
					end
					OP_DATA: begin
						if (scanning_q) begin
							seen_q <= seen_new;
							if (hit || head.last) begin
								scanning_q <= 1'b0;
							end
						end
					end
					OP_WRITE: begin
					end
					default: begin
					end
				endcase
			end

			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.found         = found_q;
	assign res.match_address = addr_q;

endmodule

@@ design/mbps_checker.sv @@
// Port-level checker of the masked byte pattern scanner and its bind statement.
module mbps_checker import mbps_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_found,
	input logic [ADDR_W-1:0]  res_match_address
);

	// A result waiting on the sink stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item withdrawn before it was taken");

	// A stalled result keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_found) && $stable(res_match_address))
		else $error("result payload changed while stalled");

	// A not-found result reports address zero.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_match_address == '0)
		else $error("not-found result carries a nonzero address");

	// A sampled reset leaves no result pending in the following cycle.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result offered right after reset");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_found         (res.found),
	.res_match_address (res.match_address)
);
